/* sv/pbr_pkg.sv */
package pbr_pkg;

	localparam int PX_W     = 32;
	localparam int CH_W     = 8;
	localparam int FRAC_W   = 9;
	localparam int WGT_W    = 17;
	localparam int CA_W     = 16;
	localparam int AW_W     = 25;
	localparam int CAW_W    = 32;
	localparam int DVD_W    = 17;
	localparam int NUM_PX   = 4;
	localparam int NUM_COL  = 3;
	localparam int WGT_SHIFT = 16;

	localparam logic [FRAC_W-1:0] WEIGHT_ONE = 9'd256;
	localparam logic [CH_W-1:0]   CHAN_MAX   = 8'hFF;

	typedef logic [NUM_PX-1:0][PX_W-1:0]                px_quad_t;
	typedef logic [NUM_PX-1:0][WGT_W-1:0]               wgt_quad_t;
	typedef logic [NUM_PX-1:0][NUM_COL-1:0][CA_W-1:0]   ca_quad_t;
	typedef logic [NUM_PX-1:0][AW_W-1:0]                aw_quad_t;
	typedef logic [NUM_PX-1:0][NUM_COL-1:0][CAW_W-1:0]  caw_quad_t;

	typedef struct packed {
		logic [CH_W-1:0]                   alpha;
		logic                              zero;
		logic [NUM_COL-1:0][DVD_W-1:0]     dividend;
	} div_in_t;

	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic [CH_W-1:0] low;
		logic [CH_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic [CH_W-1:0]               alpha;
		logic                          zero;
		logic [NUM_COL-1:0]            sat;
		div_lane_t [NUM_COL-1:0]       lane;
	} div_stage_t;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	function automatic div_lane_t div_step(div_lane_t l, logic [CH_W-1:0] d);
		logic [CH_W:0] r9;
		div_lane_t o;
		r9 = {l.rem, l.low[CH_W-1]};
		o.low = {l.low[CH_W-2:0], 1'b0};
		if (r9 >= {1'b0, d}) begin
			o.rem = CH_W'(r9 - {1'b0, d});
			o.quo = {l.quo[CH_W-2:0], 1'b1};
		end else begin
			o.rem = r9[CH_W-1:0];
			o.quo = {l.quo[CH_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic div_stage_t div_pair(div_stage_t s);
		div_stage_t o;
		o = s;
		for (int c = 0; c < NUM_COL; c++) begin
			o.lane[c] = div_step(div_step(s.lane[c], s.alpha), s.alpha);
		end
		return o;
	endfunction

endpackage

/* sv/pbr_in_if.sv */
interface pbr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] top_left;
	logic [31:0] top_right;
	logic [31:0] bottom_left;
	logic [31:0] bottom_right;
	logic [8:0]  weight_x;
	logic [8:0]  weight_y;

	modport source (
		output valid, top_left, top_right, bottom_left, bottom_right, weight_x, weight_y,
		input  ready
	);
	modport sink (
		input  valid, top_left, top_right, bottom_left, bottom_right, weight_x, weight_y,
		output ready
	);
endinterface

/* sv/pbr_out_if.sv */
interface pbr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] blended_pixel;

	modport source (
		output valid, blended_pixel,
		input  ready
	);
	modport sink (
		input  valid, blended_pixel,
		output ready
	);
endinterface

/* sv/premultiplied_bilinear_rgba.sv */
// Bilinear blend of four RGBA8888 neighbor pixels with premultiplied alpha.
//
// The pixels channel carries the four neighbors and the two 9-bit fractions
// (256 means fully toward the right column or bottom row; larger codes act as
// 256). The result channel carries one straight-alpha pixel per input, in
// order. A transfer happens on a clock edge where valid and ready are high.
//
// Four stages form the weights, the premultiplied products and the sums, and
// four more run the rounded division by alpha, two restoring steps per stage.
// A new input is taken every cycle while the receiver keeps result.ready high,
// so throughput is one pixel per clock.
//
// Reset clears every valid bit, so the block comes up empty and ready. When
// the receiver holds ready low, the stages behind the waiting result keep
// filling until they are all occupied; only then does pixels.ready drop. No
// transfer is lost or repeated.
module premultiplied_bilinear_rgba
	import pbr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pbr_in_if.sink       pixels,
	pbr_out_if.source    result
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        en1, en2, en3, en4;
	logic        div_ready;

	px_quad_t    px_s1;
	wgt_quad_t   w_s1, w_s2;
	ca_quad_t    ca_s2;
	aw_quad_t    aw_s2;
	caw_quad_t   caw_s3;
	logic [CH_W-1:0] alpha_s3;
	div_in_t     div_s4;

	logic [FRAC_W-1:0] fx, fy, ix, iy;
	wgt_quad_t         w_next;
	logic [AW_W+1:0]   asum;
	logic [CH_W-1:0]   alpha_next;
	div_in_t           div_next;
	logic [NUM_COL-1:0][CAW_W+1:0] psum;

	assign en4 = !v_s4 || div_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixels.ready = en1;

	always_comb begin
		fx = (pixels.weight_x > WEIGHT_ONE) ? WEIGHT_ONE : pixels.weight_x;
		fy = (pixels.weight_y > WEIGHT_ONE) ? WEIGHT_ONE : pixels.weight_y;
		ix = WEIGHT_ONE - fx;
		iy = WEIGHT_ONE - fy;
		w_next[0] = WGT_W'(ix) * WGT_W'(iy);
		w_next[1] = WGT_W'(fx) * WGT_W'(iy);
		w_next[2] = WGT_W'(ix) * WGT_W'(fy);
		w_next[3] = WGT_W'(fx) * WGT_W'(fy);
	end

	always_comb begin
		asum = '0;
		for (int i = 0; i < NUM_PX; i++) begin
			asum = asum + (AW_W+2)'(aw_s2[i]);
		end
		if (asum[AW_W+1:WGT_SHIFT+CH_W] != '0) begin
			alpha_next = CHAN_MAX;
		end else begin
			alpha_next = asum[WGT_SHIFT+CH_W-1:WGT_SHIFT];
		end
	end

	always_comb begin
		div_next.alpha = alpha_s3;
		div_next.zero  = (alpha_s3 == '0);
		for (int c = 0; c < NUM_COL; c++) begin
			psum[c] = '0;
			for (int i = 0; i < NUM_PX; i++) begin
				psum[c] = psum[c] + (CAW_W+2)'(caw_s3[i][c]);
			end
			div_next.dividend[c] = DVD_W'(psum[c][WGT_SHIFT+CA_W-1:WGT_SHIFT])
				+ DVD_W'(alpha_s3[CH_W-1:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixels.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1 <= {pixels.bottom_right, pixels.bottom_left,
				pixels.top_right, pixels.top_left};
			w_s1  <= w_next;
		end
		if (en2) begin
			w_s2 <= w_s1;
			for (int i = 0; i < NUM_PX; i++) begin
				aw_s2[i] <= AW_W'(px_s1[i][CH_W-1:0]) * AW_W'(w_s1[i]);
				for (int c = 0; c < NUM_COL; c++) begin
					ca_s2[i][c] <= CA_W'(px_s1[i][PX_W-1-CH_W*c -: CH_W])
						* CA_W'(px_s1[i][CH_W-1:0]);
				end
			end
		end
		if (en3) begin
			alpha_s3 <= alpha_next;
			for (int i = 0; i < NUM_PX; i++) begin
				for (int c = 0; c < NUM_COL; c++) begin
					caw_s3[i][c] <= CAW_W'((CAW_W+1)'(ca_s2[i][c]) * (CAW_W+1)'(w_s2[i]));
				end
			end
		end
		if (en4) div_s4 <= div_next;
	end

	pbr_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_ready),
		.in_data   (div_s4),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.pixel     (result.blended_pixel)
	);

endmodule

/* sv/pbr_divider.sv */
module pbr_divider
	import pbr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  div_in_t             in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PX_W-1:0]     pixel
);

	logic       v_s1, v_s2, v_s3, v_s4;
	logic       en1, en2, en3, en4;
	div_stage_t d_s1, d_s2, d_s3;
	div_stage_t first, last;
	logic [NUM_COL-1:0][CH_W-1:0] chan;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// The quotient fits in eight bits unless the dividend reaches 256 times alpha.
	always_comb begin
		first.alpha = in_data.alpha;
		first.zero  = in_data.zero;
		for (int c = 0; c < NUM_COL; c++) begin
			first.sat[c]      = in_data.dividend[c][DVD_W-1:CH_W] >= {1'b0, in_data.alpha};
			first.lane[c].rem = in_data.dividend[c][2*CH_W-1:CH_W];
			first.lane[c].low = in_data.dividend[c][CH_W-1:0];
			first.lane[c].quo = '0;
		end
	end

	always_comb begin
		last = div_pair(d_s3);
		for (int c = 0; c < NUM_COL; c++) begin
			chan[c] = last.sat[c] ? CHAN_MAX : last.lane[c].quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) d_s1 <= div_pair(first);
		if (en2) d_s2 <= div_pair(d_s1);
		if (en3) d_s3 <= div_pair(d_s2);
		if (en4) begin
			if (last.zero) begin
				pixel <= '0;
			end else begin
				pixel <= {chan[0], chan[1], chan[2], last.alpha};
			end
		end
	end

	assign out_valid = v_s4;

endmodule
